[hw/rtl/assert_macros.svh]
// Assertion macros shared by the slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked at every rising edge outside reset.
`define RRSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A condition that must never be seen outside reset.
`define RRSA_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

[hw/rtl/rrsa_pkg.sv]
// Shared types and constants of the round-robin slot allocator.
package rrsa_pkg;

   localparam int DEF_NUM_SLOTS = 256;
   localparam int CELL_SLOTS    = 16;
   localparam int OFF_W         = $clog2(CELL_SLOTS);

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_EPOCH   = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SLOT_FREE = 2'd0,
      SLOT_USED = 2'd1,
      SLOT_DEAD = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_RELEASE,
      OP_EPOCH,
      OP_CLEAR,
      OP_GRANT
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_FINISH
   } ctrl_state_type;

   // Flags of the scan token that runs down the chain of cells.
   typedef struct packed {
      logic valid;
      logic hi_found;
      logic any_found;
      logic used_any;
   } scan_flags_type;

endpackage

[hw/rtl/round_robin_slot_allocator.sv]
// Top level of the round-robin slot allocator: chain of slot cells and sequencer.
//
// The allocator keeps NUM_SLOTS slots, each free, used or dead, spread over a chain of
// cells holding sixteen slots apiece. Every command beat is handled on its own: a
// release, new-epoch or clear updates the cells in the cycle it is accepted, then a
// scan token walks the chain one cell per cycle, collecting the first free slot at or
// above the search pointer, the first free slot overall (the wrapped case) and whether
// any slot is used. An allocate commits its grant and moves the pointer as its result
// is loaded. A beat passes the launch state, the chain of cells, the wait state and the
// finish state, which holds while an earlier result is not yet taken; the result sits in
// an output register, so the next request beat is taken while an earlier result waits.
// Reset frees all slots and clears the pointer at once; no clearing pass is needed.
module round_robin_slot_allocator #(
   parameter int NUM_SLOTS = rrsa_pkg::DEF_NUM_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_slot_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [7:0] rsp_granted_slot,
   output logic       rsp_any_used
);
   import rrsa_pkg::*;

   localparam int IDX_W     = $clog2(NUM_SLOTS);
   localparam int NUM_CELLS = (NUM_SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;

   cell_op_type      cell_op;
   logic [IDX_W-1:0] cell_idx;
   logic [IDX_W-1:0] ptr;
   logic             launch;

   // Links of the scan chain; link k feeds cell k, the last link is the tail.
   scan_flags_type   link_flags   [NUM_CELLS+1];
   logic [IDX_W-1:0] link_hi_idx  [NUM_CELLS+1];
   logic [IDX_W-1:0] link_any_idx [NUM_CELLS+1];

   // A fresh token enters the head with nothing found yet.
   assign link_flags[0]   = scan_flags_type'{valid: launch, hi_found: 1'b0,
                                             any_found: 1'b0, used_any: 1'b0};
   assign link_hi_idx[0]  = '0;
   assign link_any_idx[0] = '0;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      rrsa_cell #(
         .NUM_SLOTS (NUM_SLOTS),
         .IDX_W     (IDX_W),
         .CELL_ID   (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .op_idx      (cell_idx),
         .ptr         (ptr),
         .carry_in    (link_flags[k]),
         .hi_idx_in   (link_hi_idx[k]),
         .any_idx_in  (link_any_idx[k]),
         .carry_out   (link_flags[k+1]),
         .hi_idx_out  (link_hi_idx[k+1]),
         .any_idx_out (link_any_idx[k+1])
      );
   end

   rrsa_ctrl #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W),
      .NUM_CELLS (NUM_CELLS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_any_used     (rsp_any_used),
      .cell_op          (cell_op),
      .cell_idx         (cell_idx),
      .ptr              (ptr),
      .launch           (launch),
      .tail             (link_flags[NUM_CELLS]),
      .tail_hi_idx      (link_hi_idx[NUM_CELLS]),
      .tail_any_idx     (link_any_idx[NUM_CELLS])
   );

endmodule

[hw/rtl/rrsa_cell.sv]
// One cell of the chain: a group of slots and one stage of the scan token.
module rrsa_cell #(
   parameter int NUM_SLOTS = 256,
   parameter int IDX_W     = 8,
   parameter int CELL_ID   = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rrsa_pkg::cell_op_type    op,
   input  logic [IDX_W-1:0]         op_idx,
   input  logic [IDX_W-1:0]         ptr,
   input  rrsa_pkg::scan_flags_type carry_in,
   input  logic [IDX_W-1:0]         hi_idx_in,
   input  logic [IDX_W-1:0]         any_idx_in,
   output rrsa_pkg::scan_flags_type carry_out,
   output logic [IDX_W-1:0]         hi_idx_out,
   output logic [IDX_W-1:0]         any_idx_out
);
   import rrsa_pkg::*;

   slot_state_type slot_ff [CELL_SLOTS];
   slot_state_type slot_in [CELL_SLOTS];

   scan_flags_type   carry_ff, carry_in_nx;
   logic [IDX_W-1:0] hi_idx_ff, hi_idx_in_nx;
   logic [IDX_W-1:0] any_idx_ff, any_idx_in_nx;

   logic [CELL_SLOTS-1:0] exists, free_v, hi_v, used_v;
   logic [IDX_W-1:0]      gidx [CELL_SLOTS];
   logic [OFF_W-1:0]      hi_off, any_off;

   always_comb begin
      for (int j = 0; j < CELL_SLOTS; j++) begin
         exists[j] = (CELL_ID * CELL_SLOTS + j) < NUM_SLOTS;
         gidx[j]   = IDX_W'(CELL_ID * CELL_SLOTS + j);
         free_v[j] = exists[j] && (slot_ff[j] == SLOT_FREE);
         hi_v[j]   = free_v[j] && (gidx[j] >= ptr);
         used_v[j] = exists[j] && (slot_ff[j] == SLOT_USED);
      end
   end

   // Lowest free slot in the group, overall and at or above the pointer.
   always_comb begin
      hi_off  = '0;
      any_off = '0;
      for (int j = CELL_SLOTS - 1; j >= 0; j--) begin
         if (hi_v[j]) hi_off = OFF_W'(j);
         if (free_v[j]) any_off = OFF_W'(j);
      end
   end

   // Earlier cells hold lower slots, so a find already in the token wins.
   always_comb begin
      carry_in_nx   = carry_in;
      hi_idx_in_nx  = hi_idx_in;
      any_idx_in_nx = any_idx_in;
      if (!carry_in.hi_found && (|hi_v)) begin
         carry_in_nx.hi_found = 1'b1;
         hi_idx_in_nx         = IDX_W'(CELL_ID * CELL_SLOTS + int'(hi_off));
      end
      if (!carry_in.any_found && (|free_v)) begin
         carry_in_nx.any_found = 1'b1;
         any_idx_in_nx         = IDX_W'(CELL_ID * CELL_SLOTS + int'(any_off));
      end
      carry_in_nx.used_any = carry_in.used_any | (|used_v);
   end

   always_comb begin
      for (int j = 0; j < CELL_SLOTS; j++) begin
         slot_in[j] = slot_ff[j];
         unique case (op)
            OP_NONE: ;
            OP_RELEASE: if (exists[j] && gidx[j] == op_idx) slot_in[j] = SLOT_DEAD;
            OP_EPOCH:   if (slot_ff[j] == SLOT_DEAD) slot_in[j] = SLOT_FREE;
            OP_CLEAR:   slot_in[j] = SLOT_FREE;
            OP_GRANT:   if (exists[j] && gidx[j] == op_idx) slot_in[j] = SLOT_USED;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CELL_SLOTS; j++) slot_ff[j] <= SLOT_FREE;
         carry_ff <= '0;
      end else begin
         for (int j = 0; j < CELL_SLOTS; j++) slot_ff[j] <= slot_in[j];
         carry_ff <= carry_in_nx;
      end
      hi_idx_ff  <= hi_idx_in_nx;
      any_idx_ff <= any_idx_in_nx;
   end

   assign carry_out   = carry_ff;
   assign hi_idx_out  = hi_idx_ff;
   assign any_idx_out = any_idx_ff;

endmodule

[hw/rtl/rrsa_ctrl.sv]
// Command sequencer, search pointer and result register of the slot allocator.
`include "assert_macros.svh"

module rrsa_ctrl #(
   parameter int NUM_SLOTS = 256,
   parameter int IDX_W     = 8,
   parameter int NUM_CELLS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_command,
   input  logic [7:0]               req_slot_index,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_status,
   output logic [7:0]               rsp_granted_slot,
   output logic                     rsp_any_used,
   output rrsa_pkg::cell_op_type    cell_op,
   output logic [IDX_W-1:0]         cell_idx,
   output logic [IDX_W-1:0]         ptr,
   output logic                     launch,
   input  rrsa_pkg::scan_flags_type tail,
   input  logic [IDX_W-1:0]         tail_hi_idx,
   input  logic [IDX_W-1:0]         tail_any_idx
);
   import rrsa_pkg::*;

   localparam int CMP_W = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

   ctrl_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             res_found_ff, res_found_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic             res_used_ff, res_used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_granted_ff, rsp_granted_in;
   logic             rsp_any_used_ff, rsp_any_used_in;

   logic             rsp_free, grant;
   logic [CMP_W-1:0] req_idx_wide, res_idx_wide;

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign req_idx_wide = CMP_W'(req_slot_index);
   assign res_idx_wide = CMP_W'(res_idx_ff);
   assign grant        = (cmd_ff == CMD_ALLOC) && res_found_ff;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      ptr_in          = ptr_ff;
      res_found_in    = res_found_ff;
      res_idx_in      = res_idx_ff;
      res_used_in     = res_used_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_granted_in  = rsp_granted_ff;
      rsp_any_used_in = rsp_any_used_ff;
      req_ready       = 1'b0;
      launch          = 1'b0;
      cell_op         = OP_NONE;
      cell_idx        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_command);
               state_in = ST_LAUNCH;
               unique case (cmd_type'(req_command))
                  CMD_ALLOC: ;
                  CMD_RELEASE: begin
                     if (req_idx_wide < CMP_W'(NUM_SLOTS)) begin
                        cell_op  = OP_RELEASE;
                        cell_idx = req_idx_wide[IDX_W-1:0];
                     end
                  end
                  CMD_EPOCH: cell_op = OP_EPOCH;
                  CMD_CLEAR: cell_op = OP_CLEAR;
                  default: ;
               endcase
            end
         end
         ST_LAUNCH: begin
            launch   = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (tail.valid) begin
               res_found_in = tail.hi_found || tail.any_found;
               res_idx_in   = tail.hi_found ? tail_hi_idx : tail_any_idx;
               res_used_in  = tail.used_any;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = (cmd_ff == CMD_ALLOC) && !res_found_ff;
               rsp_granted_in  = grant ? res_idx_wide[7:0] : 8'd0;
               rsp_any_used_in = grant || res_used_ff;
               if (grant) begin
                  cell_op  = OP_GRANT;
                  cell_idx = res_idx_ff;
                  ptr_in   = res_idx_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff          <= cmd_in;
      res_found_ff    <= res_found_in;
      res_idx_ff      <= res_idx_in;
      res_used_ff     <= res_used_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_granted_ff  <= rsp_granted_in;
      rsp_any_used_ff <= rsp_any_used_in;
   end

   assign ptr              = ptr_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_any_used     = rsp_any_used_ff;

   `RRSA_ASSERT(a_token_latency, clock, reset, (state_ff == ST_LAUNCH) |-> ##NUM_CELLS tail.valid, "scan token did not reach the chain tail in time")
   `RRSA_ASSERT(a_tail_in_wait, clock, reset, tail.valid |-> (state_ff == ST_WAIT), "scan token arrived outside the wait state")
   `RRSA_ASSERT(a_full_no_grant, clock, reset, (rsp_valid && rsp_status) |-> (rsp_granted_slot == 8'd0), "full report carries a granted slot")
   `RRSA_ASSERT(a_grant_moves_ptr, clock, reset, (cell_op == OP_GRANT) |=> (ptr_ff == $past(cell_idx)), "grant did not move the search pointer")

endmodule
